### rtl/lcbf_pkg.sv
// Package for the bypass fader: fade and config types, constants and
// register codes. No dependencies.

package lcbf_pkg;

   localparam int FADE_BITS     = 17;
   localparam int DELAY_BITS    = 12;
   localparam int CSR_DATA_BITS = 17;
   localparam int CSR_IDX_BITS  = 1;

   typedef logic [FADE_BITS-1:0]     fade_type;
   typedef logic [DELAY_BITS-1:0]    delay_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;
   typedef logic [CSR_IDX_BITS-1:0]  csr_index_type;

   localparam fade_type      FADE_FULL          = 17'h10000;
   localparam fade_type      FADE_STEP_RESET    = 17'd114;
   localparam int            DELAY_RESET        = 2048;
   localparam csr_index_type CSR_DELAY_SAMPLES  = 1'b0;
   localparam csr_index_type CSR_FADE_STEP      = 1'b1;

endpackage

### rtl/lcbf_req_if.sv
// Input channel of the bypass fader: dry pair, wet pair, bypass request.
// Depends on lcbf_pkg.

interface lcbf_req_if #(
   parameter int SAMPLE_BITS = 24
);
   import lcbf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] dry_left;
   logic signed [SAMPLE_BITS-1:0] dry_right;
   logic signed [SAMPLE_BITS-1:0] wet_left;
   logic signed [SAMPLE_BITS-1:0] wet_right;
   logic                          bypass;

   modport source (
      output valid, dry_left, dry_right, wet_left, wet_right, bypass,
      input  ready
   );
   modport sink (
      input  valid, dry_left, dry_right, wet_left, wet_right, bypass,
      output ready
   );
endinterface

### rtl/lcbf_rsp_if.sv
// Result channel of the bypass fader: mixed pair and fade level.
// Depends on lcbf_pkg.

interface lcbf_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   import lcbf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;
   fade_type                      fade_level;

   modport source (
      output valid, out_left, out_right, fade_level,
      input  ready
   );
   modport sink (
      input  valid, out_left, out_right, fade_level,
      output ready
   );
endinterface

### rtl/lcbf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.

module lcbf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/latency_compensated_bypass_fader.sv
// Delay-compensated bypass crossfade: dry ring in lcbf_ram, fade ramp and
// three-stage mix. Depends on lcbf_pkg, lcbf_req_if, lcbf_rsp_if, lcbf_ram.
//
//   channel   direction  handshake      payload
//   req_item  in         valid/ready    dry_left, dry_right, wet_left, wet_right, bypass
//   rsp_item  out        valid/ready    out_left, out_right, fade_level
//   csr_*     in         csr_wr_en      csr_index, csr_wdata
//
// One item per cycle sustained while rsp ready holds; three register stages
// (ring read, multiply, round and add); the first stage is the RAM read.
// Reset is synchronous; ring entries not yet written since reset read as zero
// through a wrap flag, so there is no clearing pass.
// Each stage holds while the stage after it is full and stalled.

module latency_compensated_bypass_fader #(
   parameter int RING_DEPTH  = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   lcbf_req_if.sink               req_item,
   lcbf_rsp_if.source             rsp_item,
   input  logic                   csr_wr_en,
   input  lcbf_pkg::csr_index_type csr_index,
   input  lcbf_pkg::csr_data_type  csr_wdata
);
   import lcbf_pkg::*;

   localparam int AW    = $clog2(RING_DEPTH);
   localparam int SB    = SAMPLE_BITS;
   localparam int PW    = SB + 1 + FADE_BITS + 1;
   localparam int RECIP = (1 << 24) / RING_DEPTH;
   localparam logic [AW-1:0] DELAY_RESET_MOD = AW'(DELAY_RESET % RING_DEPTH);
   localparam logic [AW-1:0] LAST_POS        = AW'(RING_DEPTH - 1);
   localparam logic signed [PW-1:0] ROUND_BIAS = PW'(32768);

   // configuration
   logic [AW-1:0] delay_ff, delay_in;
   fade_type      step_ff;
   logic [32:0]   delay_prod;
   logic [8:0]    delay_quot;
   logic [31:0]   delay_rem;

   always_comb begin
      delay_prod = 33'(csr_wdata[DELAY_BITS-1:0]) * 33'(RECIP);
      delay_quot = delay_prod[32:24];
      delay_rem  = 32'(csr_wdata[DELAY_BITS-1:0]) - 32'(delay_quot) * 32'(RING_DEPTH);
      if (delay_rem >= 32'(RING_DEPTH)) begin
         delay_rem = delay_rem - 32'(RING_DEPTH);
      end
      delay_in = delay_rem[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET_MOD;
         step_ff  <= FADE_STEP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DELAY_SAMPLES: delay_ff <= delay_in;
            CSR_FADE_STEP:     step_ff  <= csr_wdata[FADE_BITS-1:0];
            default:           ;
         endcase
      end
   end

   // handshake
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic out_ready, s2_ready, s1_ready, accept;

   assign out_ready      = !out_valid_ff || rsp_item.ready;
   assign s2_ready       = !s2_valid_ff || out_ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_item.ready = s1_ready;
   assign accept         = req_item.valid && s1_ready;

   // ring addressing and fade ramp
   logic [AW-1:0]   wpos_ff, wpos_in, rpos;
   logic            wrapped_ff;
   logic [FADE_BITS:0] fade_sum;
   fade_type        fade_ff, fade_in;
   logic [2*SB-1:0] ram_q;

   always_comb begin
      if (wpos_ff >= delay_ff) begin
         rpos = wpos_ff - delay_ff;
      end else begin
         rpos = AW'((AW+1)'(wpos_ff) + (AW+1)'(RING_DEPTH) - (AW+1)'(delay_ff));
      end
      wpos_in = (wpos_ff == LAST_POS) ? '0 : wpos_ff + AW'(1);
      fade_sum = (FADE_BITS+1)'(fade_ff) + (FADE_BITS+1)'(step_ff);
      if (req_item.bypass) begin
         fade_in = (fade_sum > (FADE_BITS+1)'(FADE_FULL)) ? FADE_FULL
                                                          : fade_sum[FADE_BITS-1:0];
      end else begin
         fade_in = (fade_ff > step_ff) ? fade_ff - step_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff    <= '0;
         wrapped_ff <= 1'b0;
         fade_ff    <= '0;
      end else if (accept) begin
         wpos_ff <= wpos_in;
         fade_ff <= fade_in;
         if (wpos_ff == LAST_POS) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   lcbf_ram #(
      .WIDTH (2 * SB),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wpos_ff),
      .wr_data ({req_item.dry_left, req_item.dry_right}),
      .rd_en   (accept),
      .rd_addr (rpos),
      .rd_data (ram_q)
   );

   // stage 1: select delayed dry, multiply difference by fade
   logic                 s1_fwd_ff, s1_zero_ff;
   logic signed [SB-1:0] s1_dry_l_ff, s1_dry_r_ff, s1_wet_l_ff, s1_wet_r_ff;
   fade_type             s1_fade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_fwd_ff   <= (delay_ff == '0);
         s1_zero_ff  <= !wrapped_ff && (rpos >= wpos_ff);
         s1_dry_l_ff <= req_item.dry_left;
         s1_dry_r_ff <= req_item.dry_right;
         s1_wet_l_ff <= req_item.wet_left;
         s1_wet_r_ff <= req_item.wet_right;
         s1_fade_ff  <= fade_in;
      end
   end

   logic signed [SB-1:0]        dly_l, dly_r;
   logic signed [SB:0]          diff_l, diff_r;
   logic signed [FADE_BITS:0]   fade_s;
   logic signed [PW-1:0]        prod_l_in, prod_r_in;

   always_comb begin
      if (s1_fwd_ff) begin
         dly_l = s1_dry_l_ff;
         dly_r = s1_dry_r_ff;
      end else if (s1_zero_ff) begin
         dly_l = '0;
         dly_r = '0;
      end else begin
         dly_l = ram_q[2*SB-1:SB];
         dly_r = ram_q[SB-1:0];
      end
      diff_l    = (SB+1)'(dly_l) - (SB+1)'(s1_wet_l_ff);
      diff_r    = (SB+1)'(dly_r) - (SB+1)'(s1_wet_r_ff);
      fade_s    = $signed({1'b0, s1_fade_ff});
      prod_l_in = diff_l * fade_s;
      prod_r_in = diff_r * fade_s;
   end

   // stage 2: round and add to wet
   logic signed [PW-1:0] s2_prod_l_ff, s2_prod_r_ff;
   logic signed [SB-1:0] s2_wet_l_ff, s2_wet_r_ff;
   fade_type             s2_fade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_prod_l_ff <= prod_l_in;
         s2_prod_r_ff <= prod_r_in;
         s2_wet_l_ff  <= s1_wet_l_ff;
         s2_wet_r_ff  <= s1_wet_r_ff;
         s2_fade_ff   <= s1_fade_ff;
      end
   end

   logic signed [PW-1:0] mix_l, mix_r;
   logic signed [SB-1:0] out_l_in, out_r_in;

   always_comb begin
      mix_l    = (s2_prod_l_ff + ROUND_BIAS) >>> 16;
      mix_r    = (s2_prod_r_ff + ROUND_BIAS) >>> 16;
      out_l_in = s2_wet_l_ff + mix_l[SB-1:0];
      out_r_in = s2_wet_r_ff + mix_r[SB-1:0];
   end

   // output register
   logic signed [SB-1:0] out_l_ff, out_r_ff;
   fade_type             out_fade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         out_l_ff    <= out_l_in;
         out_r_ff    <= out_r_in;
         out_fade_ff <= s2_fade_ff;
      end
   end

   assign rsp_item.valid      = out_valid_ff;
   assign rsp_item.out_left   = out_l_ff;
   assign rsp_item.out_right  = out_r_ff;
   assign rsp_item.fade_level = out_fade_ff;
endmodule

### tb/sv/latency_compensated_bypass_fader_tb.sv
// Testbench for latency_compensated_bypass_fader: a directed table, then random
// stereo frames under several idle and stall patterns, checked against a local mixer.
// Depends on lcbf_pkg, lcbf_req_if, lcbf_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module latency_compensated_bypass_fader_tb;
   import lcbf_pkg::*;

   localparam int SAMPLE_BITS = 24;
   localparam int RING_DEPTH  = 4096;
   localparam int LAT_PAUSE   = 8;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type S_MAX = 24'sh7FFFFF;
   localparam sample_type S_MIN = 24'sh800000;

   typedef struct {
      sample_type dry_l;
      sample_type dry_r;
      sample_type wet_l;
      sample_type wet_r;
      logic       bypass;
   } frame_type;

   typedef struct {
      sample_type out_l;
      sample_type out_r;
      fade_type   fade;
   } mix_type;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type idx;
      csr_data_type  data;
      frame_type     f;
      bit            typed;
      mix_type       want;
   } row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   lcbf_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   lcbf_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   latency_compensated_bypass_fader #(
      .RING_DEPTH (RING_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_bus),
      .rsp_item (rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("latency_compensated_bypass_fader regression: fail");
      $finish;
   end

   // local copy of the block state
   sample_type  hist_l [RING_DEPTH];
   sample_type  hist_r [RING_DEPTH];
   logic [11:0] wr_pos;
   fade_type    fade_pos;
   delay_type   delay_set;
   logic [16:0] step_set;

   mix_type       mix_due [$];
   row_type       dir_rows [$];
   int            fail_count = 0;
   idle_mode_type cur_mode = IDLE_NONE;
   bit            typed_has = 1'b0;
   mix_type       typed_mix;
   int            snk_hold_req = 0;
   int            snk_hold_left = 0;
   int            byp_left = 0;
   logic          byp_now = 1'b0;

   function automatic sample_type blend(sample_type wet, sample_type dry, fade_type f);
      longint lw, ld, lf, acc;
      lw  = wet;
      ld  = dry;
      lf  = f;
      acc = lw * (65536 - lf) + ld * lf;
      acc = (acc + 32768) >>> 16;
      return acc[SAMPLE_BITS-1:0];
   endfunction

   function automatic mix_type mix_frame(frame_type f);
      mix_type     m;
      logic [11:0] rd;
      int unsigned sum;
      hist_l[wr_pos] = f.dry_l;
      hist_r[wr_pos] = f.dry_r;
      rd     = wr_pos - delay_set;
      wr_pos = wr_pos + 12'd1;
      if (f.bypass) begin
         sum      = fade_pos + step_set;
         fade_pos = (sum > FADE_FULL) ? FADE_FULL : sum[16:0];
      end else begin
         fade_pos = (fade_pos > step_set) ? fade_pos - step_set : '0;
      end
      m.out_l = blend(f.wet_l, hist_l[rd], fade_pos);
      m.out_r = blend(f.wet_r, hist_r[rd], fade_pos);
      m.fade  = fade_pos;
      return m;
   endfunction

   task automatic report_fail(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   function automatic bit src_idle();
      case (cur_mode)
         IDLE_SRC:  return $urandom_range(0, 99) < 83;
         IDLE_BOTH: return $urandom_range(0, 99) < 24;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic bit snk_stall();
      case (cur_mode)
         IDLE_SNK:  return $urandom_range(0, 99) < 83;
         IDLE_BOTH: return $urandom_range(0, 99) < 24;
         default:   return 1'b0;
      endcase
   endfunction

   always @(negedge clock) begin
      if (snk_hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         snk_hold_left--;
      end else if (snk_hold_req != 0) begin
         rsp_bus.ready <= 1'b0;
         snk_hold_left = snk_hold_req - 1;
         snk_hold_req  = 0;
      end else begin
         rsp_bus.ready <= !snk_stall();
      end
   end

   always @(posedge clock) begin
      frame_type f;
      mix_type   want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            f.dry_l  = req_bus.dry_left;
            f.dry_r  = req_bus.dry_right;
            f.wet_l  = req_bus.wet_left;
            f.wet_r  = req_bus.wet_right;
            f.bypass = req_bus.bypass;
            want = mix_frame(f);
            if (typed_has)
               want = typed_mix;
            mix_due.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (mix_due.size() == 0) begin
               report_fail("result arrived with no item pending");
            end else begin
               want = mix_due.pop_front();
               if (rsp_bus.out_left !== want.out_l)
                  report_fail($sformatf("out_left got %0d want %0d",
                                        rsp_bus.out_left, want.out_l));
               if (rsp_bus.out_right !== want.out_r)
                  report_fail($sformatf("out_right got %0d want %0d",
                                        rsp_bus.out_right, want.out_r));
               if (rsp_bus.fade_level !== want.fade)
                  report_fail($sformatf("fade_level got %0d want %0d",
                                        rsp_bus.fade_level, want.fade));
            end
         end
      end
   end

   function automatic frame_type frm(sample_type dl, sample_type dr, sample_type wl,
                                     sample_type wr, logic b);
      frame_type f;
      f.dry_l  = dl;
      f.dry_r  = dr;
      f.wet_l  = wl;
      f.wet_r  = wr;
      f.bypass = b;
      return f;
   endfunction

   function automatic void add_item(frame_type f);
      row_type r;
      r.kind  = ROW_ITEM;
      r.f     = f;
      r.typed = 1'b0;
      dir_rows.push_back(r);
   endfunction

   function automatic void add_typed(frame_type f, sample_type want_l, sample_type want_r,
                                     fade_type want_f);
      row_type r;
      r.kind       = ROW_ITEM;
      r.f          = f;
      r.typed      = 1'b1;
      r.want.out_l = want_l;
      r.want.out_r = want_r;
      r.want.fade  = want_f;
      dir_rows.push_back(r);
   endfunction

   function automatic void add_csr(csr_index_type i, csr_data_type d);
      row_type r;
      r.kind = ROW_CSR;
      r.idx  = i;
      r.data = d;
      dir_rows.push_back(r);
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return '0;
         3:       return -1;
         4:       return sample_type'($urandom_range(0, 255) - 128);
         default: return sample_type'($urandom());
      endcase
   endfunction

   // bypass comes in runs so the fade ramps reach both ends; a few frames flip it
   function automatic frame_type rand_frame();
      frame_type f;
      if (byp_left == 0) begin
         byp_now  = ~byp_now;
         byp_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 700)
                                                : $urandom_range(1, 30);
      end
      byp_left--;
      f.bypass = ($urandom_range(0, 19) == 0) ? ~byp_now : byp_now;
      f.dry_l  = rand_sample();
      f.dry_r  = rand_sample();
      f.wet_l  = rand_sample();
      f.wet_r  = rand_sample();
      return f;
   endfunction

   task automatic send_item(frame_type f, bit has_want, mix_type want);
      @(negedge clock);
      while (src_idle()) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.dry_left  <= f.dry_l;
      req_bus.dry_right <= f.dry_r;
      req_bus.wet_left  <= f.wet_l;
      req_bus.wet_right <= f.wet_r;
      req_bus.bypass    <= f.bypass;
      typed_has = has_want;
      typed_mix = want;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (mix_due.size() != 0)
         @(posedge clock);
      repeat (LAT_PAUSE) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, csr_data_type data);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_DELAY_SAMPLES)
         delay_set = data[DELAY_BITS-1:0];
      else
         step_set = data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(delay_type d, csr_data_type step, idle_mode_type m, int count,
                            int hold);
      logic [4:0] junk;
      frame_type  f;
      mix_type    no_mix;
      junk = 5'($urandom_range(0, 31));
      write_csr(CSR_DELAY_SAMPLES, {junk, d});
      write_csr(CSR_FADE_STEP, step);
      cur_mode = m;
      if (hold > 0) begin
         @(posedge clock);
         snk_hold_req = hold;
      end
      repeat (count) begin
         f = rand_frame();
         send_item(f, 1'b0, no_mix);
      end
   endtask

   initial begin
      row_type r;
      req_bus.valid     = 1'b0;
      req_bus.dry_left  = '0;
      req_bus.dry_right = '0;
      req_bus.wet_left  = '0;
      req_bus.wet_right = '0;
      req_bus.bypass    = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_DELAY_SAMPLES;
      csr_wdata         = '0;
      foreach (hist_l[i]) begin
         hist_l[i] = '0;
         hist_r[i] = '0;
      end
      wr_pos    = '0;
      fade_pos  = '0;
      delay_set = delay_type'(DELAY_RESET);
      step_set  = FADE_STEP_RESET;

      // after reset the delayed dry reads zero, so fade 0 gives pure wet
      add_typed(frm(S_MAX, S_MIN, S_MAX, S_MIN, 1'b0), S_MAX, S_MIN, '0);
      add_typed(frm(S_MIN, S_MAX, S_MIN, S_MAX, 1'b0), S_MIN, S_MAX, '0);
      add_typed(frm('0, -1, -1, '0, 1'b0), -1, '0, '0);
      add_item(frm(1, 1, S_MAX, S_MIN, 1'b1));
      add_typed(frm(2, 2, 12345, -54321, 1'b0), 12345, -54321, '0);
      // step beyond full scale clamps
      add_csr(CSR_FADE_STEP, 17'h1FFFF);
      add_typed(frm(5, 6, S_MAX, S_MIN, 1'b1), '0, '0, FADE_FULL);
      add_csr(CSR_DELAY_SAMPLES, '0);
      add_typed(frm(S_MAX, S_MIN, '0, '0, 1'b1), S_MAX, S_MIN, FADE_FULL);
      add_typed(frm(S_MIN, S_MAX, 7, 7, 1'b1), S_MIN, S_MAX, FADE_FULL);
      add_typed(frm(S_MAX, S_MAX, -7, 8, 1'b0), -7, 8, '0);
      // zero step holds the fade
      add_csr(CSR_FADE_STEP, '0);
      add_typed(frm(S_MIN, S_MIN, 100, -100, 1'b1), 100, -100, '0);
      // half fade, rounding ties
      add_csr(CSR_FADE_STEP, 17'd32768);
      add_item(frm('0, '0, 1, -1, 1'b1));
      add_typed(frm(3, 3, S_MAX, S_MIN, 1'b0), S_MAX, S_MIN, '0);
      add_item(frm(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1));
      add_csr(CSR_DELAY_SAMPLES, 12'd1);
      add_item(frm(3, -3, 9, -9, 1'b1));
      add_item(frm(4, -4, 10, -10, 1'b1));
      add_csr(CSR_DELAY_SAMPLES, 12'd4095);
      add_csr(CSR_FADE_STEP, FADE_FULL);
      add_item(frm(S_MAX, S_MIN, 11, -11, 1'b1));
      add_typed(frm(S_MIN, S_MAX, -12, 12, 1'b0), -12, 12, '0);
      add_csr(CSR_FADE_STEP, 17'd1);
      add_item(frm(S_MAX, S_MAX, S_MIN, S_MIN, 1'b1));
      add_item(frm(S_MIN, S_MIN, S_MAX, S_MAX, 1'b1));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[k]) begin
         r = dir_rows[k];
         if (r.kind == ROW_CSR)
            write_csr(r.idx, r.data);
         else
            send_item(r.f, r.typed, r.want);
      end

      run_phase(12'd3,    17'd4096,       IDLE_NONE, 250, 0);
      run_phase(12'd0,    FADE_STEP_RESET, IDLE_SRC, 200, 0);
      run_phase(12'd1,    FADE_FULL,      IDLE_SNK,  200, 0);
      run_phase(12'd17,   17'd1,          IDLE_BOTH, 200, 0);
      run_phase(12'd4095, 17'h1FFFF,      IDLE_NONE, 200, 80);
      run_phase(12'd100,  '0,             IDLE_SRC,  150, 0);
      run_phase(12'd1000, 17'd2000,       IDLE_SNK,  250, 0);
      run_phase(delay_type'($urandom_range(0, 4095)),
                csr_data_type'($urandom_range(0, 131071)), IDLE_BOTH, 200, 0);
      run_phase(delay_type'(DELAY_RESET), FADE_STEP_RESET, IDLE_NONE, 200, 120);

      wait_drained();
      if (fail_count == 0)
         $display("latency_compensated_bypass_fader regression: pass");
      else
         $display("latency_compensated_bypass_fader regression: fail");
      $finish;
   end

endmodule
